// ===== design/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, opcodes and helpers for the Q24.8 fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACT_BITS_DEFAULT = 8;
    localparam int RAW_W              = 32;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_INC      = 4'd4,
        CMD_DEC      = 4'd5,
        CMD_MIN      = 4'd6,
        CMD_MAX      = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_FROM_INT = 4'd9
    } cmd_t;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    // Per-beat control that rides along the pipeline
    typedef struct packed {
        logic [3:0]        cmd;
        logic [RAW_W-1:0]  res;
        logic              ovf;
        logic              dbz;
        logic              gt;
        logic              lt;
        logic              eq;
        logic              neg;
    } ctl_t;

    typedef struct packed {
        logic [RAW_W-1:0] res;
        logic             ovf;
    } sat_t;

    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t s;
        s.ovf = 1'b0;
        s.res = v[RAW_W-1:0];
        if (v > SAT_MAX) begin
            s.res = SAT_MAX[RAW_W-1:0];
            s.ovf = 1'b1;
        end
        else if (v < SAT_MIN) begin
            s.res = SAT_MIN[RAW_W-1:0];
            s.ovf = 1'b1;
        end
        return s;
    endfunction

endpackage

// ===== design/fixed_point_alu_q24_8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core
// Pipelined signed fixed-point ALU: add, sub, mul, div, inc, dec, min, max,
// round to integer and integer to fixed, with saturation and compare flags.
// ----------------------------------------------------------------------------
// Accepts one beat every cycle while in_stall is low and returns one result
// beat per input beat, in order. The pipeline is four front stages (input
// register, decode and product, product rounding, saturation), then one stage
// per quotient bit of the restoring divider (32 + FRACT_BITS), then a
// rounding stage and the output register. Every opcode takes the same path.
// A stall while an output beat is valid freezes the whole pipeline and is
// reflected straight back on in_stall; no beat is dropped or repeated.
module fixed_point_alu_q24_8_core #(
    parameter int FRACT_BITS = fpa_pkg::FRACT_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         cmd,
    input  logic signed [31:0] a_raw,
    input  logic signed [31:0] b_raw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_raw,
    output logic               a_greater,
    output logic               a_less,
    output logic               a_equal,
    output logic               overflow,
    output logic               divide_by_zero
);

    localparam int QW = 32 + FRACT_BITS;
    localparam logic [63:0] HALF     = (FRACT_BITS == 0) ? 64'd0 : (64'd1 << (FRACT_BITS - 1));
    localparam logic [63:0] HALF_NEG = (FRACT_BITS == 0) ? 64'd0 : (HALF - 64'd1);

    logic adv;

    // ---------------- stage 1: input register ----------------
    logic               s1_valid_reg;
    logic [3:0]         s1_cmd_reg;
    logic signed [31:0] s1_a_reg;
    logic signed [31:0] s1_b_reg;

    // ---------------- stage 2: decode, simple ops, product ----------------
    logic               s2_valid_reg;
    fpa_pkg::ctl_t      s2_ctl_reg;
    fpa_pkg::ctl_t      s2_ctl_next;
    logic signed [63:0] s2_prod_reg;
    logic [QW-1:0]      s2_num_reg;
    logic [QW-1:0]      s2_num_next;
    logic [31:0]        s2_den_reg;
    logic [31:0]        s2_den_next;

    // ---------------- stage 3: product rounding ----------------
    logic               s3_valid_reg;
    fpa_pkg::ctl_t      s3_ctl_reg;
    logic signed [63:0] s3_mulr_reg;
    logic signed [63:0] s3_mulr_next;
    logic [QW-1:0]      s3_num_reg;
    logic [31:0]        s3_den_reg;

    // ---------------- divider stages, index 0 is stage 4 ----------------
    logic               dv_valid_reg [QW+1];
    fpa_pkg::ctl_t      dv_ctl_reg   [QW+1];
    logic [QW-1:0]      dv_num_reg   [QW+1];
    logic [31:0]        dv_rem_reg   [QW+1];
    logic [31:0]        dv_den_reg   [QW+1];

    // ---------------- quotient rounding ----------------
    logic               r1_valid_reg;
    fpa_pkg::ctl_t      r1_ctl_reg;
    logic [QW:0]        r1_q_reg;
    logic [QW:0]        r1_q_next;

    // ---------------- output register ----------------
    logic               out_valid_reg;
    logic signed [31:0] out_res_reg;
    logic [31:0]        out_res_next;
    logic               out_ovf_reg;
    logic               out_ovf_next;
    logic               out_dbz_reg;
    logic               out_gt_reg;
    logic               out_lt_reg;
    logic               out_eq_reg;

    // Whole pipe moves together; hold everything while the output beat waits
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg <= cmd;
            s1_a_reg   <= a_raw;
            s1_b_reg   <= b_raw;
        end
    end

    // Stage 2 logic
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] to_int64;
    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    fpa_pkg::sat_t      sat_s;

    always_comb
    begin
        a64   = {{32{s1_a_reg[31]}}, s1_a_reg};
        b64   = {{32{s1_b_reg[31]}}, s1_b_reg};
        a_mag = s1_a_reg[31] ? 32'(-a64) : s1_a_reg;
        b_mag = s1_b_reg[31] ? 32'(-b64) : s1_b_reg;
        to_int64 = (a64 + $signed(s1_a_reg[31] ? HALF_NEG : HALF)) >>> FRACT_BITS;

        s2_ctl_next.cmd = s1_cmd_reg;
        s2_ctl_next.res = '0;
        s2_ctl_next.ovf = 1'b0;
        s2_ctl_next.dbz = 1'b0;
        s2_ctl_next.gt  = s1_a_reg > s1_b_reg;
        s2_ctl_next.lt  = s1_a_reg < s1_b_reg;
        s2_ctl_next.eq  = s1_a_reg == s1_b_reg;
        s2_ctl_next.neg = s1_a_reg[31] ^ s1_b_reg[31];
        sat_s.res = '0;
        sat_s.ovf = 1'b0;

        case (s1_cmd_reg)
            fpa_pkg::CMD_ADD:      sat_s = fpa_pkg::sat64(a64 + b64);
            fpa_pkg::CMD_SUB:      sat_s = fpa_pkg::sat64(a64 - b64);
            fpa_pkg::CMD_INC:      sat_s = fpa_pkg::sat64(a64 + 64'sd1);
            fpa_pkg::CMD_DEC:      sat_s = fpa_pkg::sat64(a64 - 64'sd1);
            fpa_pkg::CMD_MIN:      sat_s.res = s2_ctl_next.lt ? s1_a_reg : s1_b_reg;
            fpa_pkg::CMD_MAX:      sat_s.res = s2_ctl_next.gt ? s1_a_reg : s1_b_reg;
            fpa_pkg::CMD_TO_INT:   sat_s.res = to_int64[31:0];
            fpa_pkg::CMD_FROM_INT: sat_s = fpa_pkg::sat64(a64 <<< FRACT_BITS);
            fpa_pkg::CMD_DIV:      s2_ctl_next.dbz = (s1_b_reg == 32'sd0);
            default:               sat_s.res = '0;
        endcase
        s2_ctl_next.res = sat_s.res;
        s2_ctl_next.ovf = sat_s.ovf;

        s2_num_next = QW'(a_mag) << FRACT_BITS;
        s2_den_next = b_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            dv_valid_reg[0] <= s3_valid_reg;
        end
    end

    // Stage 3: round the product, ties away from zero
    assign s3_mulr_next = (s2_prod_reg + $signed(s2_prod_reg[63] ? HALF_NEG : HALF))
                          >>> FRACT_BITS;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctl_reg  <= s2_ctl_next;
            s2_prod_reg <= s1_a_reg * s1_b_reg;
            s2_num_reg  <= s2_num_next;
            s2_den_reg  <= s2_den_next;

            s3_ctl_reg  <= s2_ctl_reg;
            s3_mulr_reg <= s3_mulr_next;
            s3_num_reg  <= s2_num_reg;
            s3_den_reg  <= s2_den_reg;
        end
    end

    // Stage 4: saturate the product, seed the divider
    fpa_pkg::sat_t mul_sat;
    fpa_pkg::ctl_t s4_ctl_next;

    always_comb
    begin
        mul_sat     = fpa_pkg::sat64(s3_mulr_reg);
        s4_ctl_next = s3_ctl_reg;
        if (s3_ctl_reg.cmd == fpa_pkg::CMD_MUL)
        begin
            s4_ctl_next.res = mul_sat.res;
            s4_ctl_next.ovf = mul_sat.ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_ctl_reg[0] <= s4_ctl_next;
            dv_num_reg[0] <= s3_num_reg;
            dv_rem_reg[0] <= '0;
            dv_den_reg[0] <= s3_den_reg;
        end
    end

    // Restoring divider: one quotient bit per stage, shifted in behind the
    // dividend bits as they leave
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [32:0] trial;
        logic        take;

        assign trial = {dv_rem_reg[k], dv_num_reg[k][QW-1]};
        assign take  = trial >= {1'b0, dv_den_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctl_reg[k+1] <= dv_ctl_reg[k];
                dv_num_reg[k+1] <= {dv_num_reg[k][QW-2:0], take};
                dv_rem_reg[k+1] <= take ? 32'(trial - {1'b0, dv_den_reg[k]}) : trial[31:0];
                dv_den_reg[k+1] <= dv_den_reg[k];
            end
        end
    end

    // Round up when twice the remainder reaches the divisor
    assign r1_q_next = {1'b0, dv_num_reg[QW]}
                     + (QW+1)'({dv_rem_reg[QW], 1'b0} >= {1'b0, dv_den_reg[QW]});

    always_comb
    begin
        out_res_next = r1_ctl_reg.res;
        out_ovf_next = r1_ctl_reg.ovf;
        if (r1_ctl_reg.cmd == fpa_pkg::CMD_DIV)
        begin
            if (r1_ctl_reg.dbz)
            begin
                out_res_next = '0;
                out_ovf_next = 1'b0;
            end
            else if (!r1_ctl_reg.neg && r1_q_reg > (QW+1)'(fpa_pkg::SAT_MAX))
            begin
                out_res_next = fpa_pkg::SAT_MAX[31:0];
                out_ovf_next = 1'b1;
            end
            else if (r1_ctl_reg.neg && r1_q_reg > (QW+1)'(64'h8000_0000))
            begin
                out_res_next = fpa_pkg::SAT_MIN[31:0];
                out_ovf_next = 1'b1;
            end
            else
            begin
                out_res_next = r1_ctl_reg.neg ? 32'(-r1_q_reg) : r1_q_reg[31:0];
                out_ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            r1_valid_reg  <= dv_valid_reg[QW];
            out_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_ctl_reg  <= dv_ctl_reg[QW];
            r1_q_reg    <= r1_q_next;
            out_res_reg <= out_res_next;
            out_ovf_reg <= out_ovf_next;
            out_dbz_reg <= r1_ctl_reg.dbz;
            out_gt_reg  <= r1_ctl_reg.gt;
            out_lt_reg  <= r1_ctl_reg.lt;
            out_eq_reg  <= r1_ctl_reg.eq;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_raw     = out_res_reg;
    assign overflow       = out_ovf_reg;
    assign divide_by_zero = out_dbz_reg;
    assign a_greater      = out_gt_reg;
    assign a_less         = out_lt_reg;
    assign a_equal        = out_eq_reg;

    // ---------------- assertions ----------------
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({a_greater, a_less, a_equal}))
        else $error("compare flags not one-hot");

    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_raw == 32'sd0 && !overflow)
        else $error("divide by zero must give zero without overflow");

    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            result_raw == 32'sh7FFF_FFFF || result_raw == 32'sh8000_0000)
        else $error("overflow without saturated result");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output hold");

endmodule

// ===== dv/tb_fixed_point_alu_q24_8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8_core
// Self-checking bench for the Q24.8 ALU. A directed table covers the operand
// extremes, every opcode, division by zero, unused opcodes and saturation.
// Random beats follow. Each result beat is checked field by field against
// hand-written values from the table or an in-bench rounding and saturating
// model of the ALU. Random idle and stall bursts are applied on both channels.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8_core;

    localparam int FB      = 8;
    localparam int LATENCY = 38 + FB;
    localparam int N_RAND  = 1000;

    typedef struct packed {
        logic signed [31:0] res;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               ovf;
        logic               dbz;
    } alu_res_t;

    typedef struct {
        logic [3:0]         cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               known;
        alu_res_t           res;
    } vec_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         cmd;
    logic signed [31:0] a_raw;
    logic signed [31:0] b_raw;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_raw;
    logic               a_greater;
    logic               a_less;
    logic               a_equal;
    logic               overflow;
    logic               divide_by_zero;

    alu_res_t pending_q[$];
    int       n_err;
    bit       quiet;

    fixed_point_alu_q24_8_core #(.FRACT_BITS(FB)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .a_raw          (a_raw),
        .b_raw          (b_raw),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_raw     (result_raw),
        .a_greater      (a_greater),
        .a_less         (a_less),
        .a_equal        (a_equal),
        .overflow       (overflow),
        .divide_by_zero (divide_by_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v,
                                                   inout logic ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // divide by 2^FB, nearest, ties away from zero
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] v);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (FB - 1))) >> FB;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic alu_res_t alu_predict(input logic [3:0] op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        alu_res_t r;
        logic signed [63:0] wa, wb, v;
        logic [63:0] num, den, q;
        logic ovf;
        wa  = a;
        wb  = b;
        v   = 0;
        ovf = 1'b0;
        r.dbz = 1'b0;
        case (op)
            fpa_pkg::CMD_ADD:      v = clamp32(wa + wb, ovf);
            fpa_pkg::CMD_SUB:      v = clamp32(wa - wb, ovf);
            fpa_pkg::CMD_MUL:      v = clamp32(round_frac(wa * wb), ovf);
            fpa_pkg::CMD_DIV:
                if (b == 0)
                    r.dbz = 1'b1;
                else
                begin
                    num = ((wa < 0) ? -wa : wa) << FB;
                    den = (wb < 0) ? -wb : wb;
                    q   = (2 * num + den) / (2 * den);
                    v   = clamp32(((wa < 0) != (wb < 0)) ? -$signed(q) : $signed(q), ovf);
                end
            fpa_pkg::CMD_INC:      v = clamp32(wa + 1, ovf);
            fpa_pkg::CMD_DEC:      v = clamp32(wa - 1, ovf);
            fpa_pkg::CMD_MIN:      v = (wa < wb) ? wa : wb;
            fpa_pkg::CMD_MAX:      v = (wa > wb) ? wa : wb;
            fpa_pkg::CMD_TO_INT:   v = round_frac(wa);
            fpa_pkg::CMD_FROM_INT: v = clamp32(wa * (64'sd1 <<< FB), ovf);
            default:               v = 0;
        endcase
        r.res = v[31:0];
        r.gt  = a > b;
        r.lt  = a < b;
        r.eq  = a == b;
        r.ovf = ovf;
        return r;
    endfunction

    // result side: random stall bursts, compare against oldest expectation
    initial
    begin
        int burst;
        alu_res_t e;
        out_stall = 1'b0;
        burst     = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    n_err++;
                end
                else
                begin
                    e = pending_q.pop_front();
                    if (result_raw !== e.res)
                    begin
                        $error("result_raw exp %0d got %0d", e.res, result_raw);
                        n_err++;
                    end
                    if (a_greater !== e.gt)
                    begin
                        $error("a_greater exp %0b got %0b", e.gt, a_greater);
                        n_err++;
                    end
                    if (a_less !== e.lt)
                    begin
                        $error("a_less exp %0b got %0b", e.lt, a_less);
                        n_err++;
                    end
                    if (a_equal !== e.eq)
                    begin
                        $error("a_equal exp %0b got %0b", e.eq, a_equal);
                        n_err++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow exp %0b got %0b", e.ovf, overflow);
                        n_err++;
                    end
                    if (divide_by_zero !== e.dbz)
                    begin
                        $error("divide_by_zero exp %0b got %0b", e.dbz, divide_by_zero);
                        n_err++;
                    end
                end
            end
            @(negedge clk);
            if (burst > 0)
                burst--;
            else if (!quiet && $urandom_range(0, 9) == 0)
                burst = $urandom_range(1, 6);
            out_stall <= (burst > 0);
        end
    end

    vec_t dir_tbl[$];

    function automatic alu_res_t mk(input logic signed [31:0] r, input logic gt,
                                    input logic lt, input logic eq,
                                    input logic ovf, input logic dbz);
        alu_res_t x;
        x = '{res: r, gt: gt, lt: lt, eq: eq, ovf: ovf, dbz: dbz};
        return x;
    endfunction

    task automatic add_row(input logic [3:0] op, input logic signed [31:0] a,
                           input logic signed [31:0] b, input logic known,
                           input alu_res_t r);
        vec_t v;
        v.cmd = op; v.a = a; v.b = b; v.known = known; v.res = r;
        dir_tbl.push_back(v);
    endtask

    // hold one beat until accepted; random idle bursts before it
    task automatic send_beat(input logic [3:0] op, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        a_raw    <= a;
        b_raw    <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1:       return $signed($urandom_range(0, 1023)) - 512;
            2:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            3:       return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            default: return $signed($urandom());
        endcase
    endfunction

    initial
    begin
        const logic signed [31:0] MX = 32'sh7FFF_FFFF;
        const logic signed [31:0] MN = 32'sh8000_0000;
        logic [3:0] op;
        logic signed [31:0] a, b;
        int wait_cnt;
        n_err    = 0;
        quiet    = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = fpa_pkg::CMD_ADD;
        a_raw    = '0;
        b_raw    = '0;

        add_row(fpa_pkg::CMD_ADD, MX, 32'sd1, 1, mk(MX, 1, 0, 0, 1, 0));
        add_row(fpa_pkg::CMD_SUB, MN, 32'sd1, 1, mk(MN, 0, 1, 0, 1, 0));
        add_row(fpa_pkg::CMD_ADD, 32'sd256, 32'sd512, 1, mk(32'sd768, 0, 1, 0, 0, 0));
        add_row(fpa_pkg::CMD_MUL, 32'sd384, 32'sd384, 0, '0);
        add_row(fpa_pkg::CMD_MUL, MX, MX, 1, mk(MX, 0, 0, 1, 1, 0));
        add_row(fpa_pkg::CMD_MUL, MN, MX, 1, mk(MN, 0, 1, 0, 1, 0));
        add_row(fpa_pkg::CMD_MUL, 32'sd1, 32'sd128, 0, '0);
        add_row(fpa_pkg::CMD_MUL, -32'sd1, 32'sd128, 0, '0);
        add_row(fpa_pkg::CMD_DIV, 32'sd512, 32'sd0, 1, mk(32'sd0, 1, 0, 0, 0, 1));
        add_row(fpa_pkg::CMD_DIV, MN, 32'sd1, 1, mk(MN, 0, 1, 0, 1, 0));
        add_row(fpa_pkg::CMD_DIV, MN, -32'sd1, 1, mk(MX, 0, 1, 0, 1, 0));
        add_row(fpa_pkg::CMD_DIV, 32'sd256, 32'sd768, 0, '0);
        add_row(fpa_pkg::CMD_DIV, -32'sd1, 32'sd512, 0, '0);
        add_row(fpa_pkg::CMD_INC, MX, 32'sd0, 1, mk(MX, 1, 0, 0, 1, 0));
        add_row(fpa_pkg::CMD_DEC, MN, 32'sd0, 1, mk(MN, 0, 1, 0, 1, 0));
        add_row(fpa_pkg::CMD_MIN, MN, MX, 1, mk(MN, 0, 1, 0, 0, 0));
        add_row(fpa_pkg::CMD_MAX, MN, MX, 1, mk(MX, 0, 1, 0, 0, 0));
        add_row(fpa_pkg::CMD_TO_INT, 32'sd128, 32'sd0, 1, mk(32'sd1, 1, 0, 0, 0, 0));
        add_row(fpa_pkg::CMD_TO_INT, -32'sd128, 32'sd0, 1, mk(-32'sd1, 0, 1, 0, 0, 0));
        add_row(fpa_pkg::CMD_TO_INT, MN, MN, 1, mk(-32'sd8388608, 0, 0, 1, 0, 0));
        add_row(fpa_pkg::CMD_FROM_INT, 32'sd3, 32'sd0, 1, mk(32'sd768, 1, 0, 0, 0, 0));
        add_row(fpa_pkg::CMD_FROM_INT, MN, 32'sd0, 1, mk(MN, 0, 1, 0, 1, 0));
        add_row(4'd10, 32'sd5, 32'sd5, 1, mk(32'sd0, 0, 0, 1, 0, 0));
        add_row(4'd15, -32'sd5, 32'sd5, 1, mk(32'sd0, 0, 1, 0, 0, 0));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tbl[i])
        begin
            pending_q.push_back(dir_tbl[i].known ? dir_tbl[i].res
                : alu_predict(dir_tbl[i].cmd, dir_tbl[i].a, dir_tbl[i].b));
            send_beat(dir_tbl[i].cmd, dir_tbl[i].a, dir_tbl[i].b);
        end

        for (int n = 0; n < N_RAND; n++)
        begin
            if (n == N_RAND / 2)
            begin
                // drain: hold off until every pending result is back
                in_valid <= 1'b0;
                while (pending_q.size() != 0)
                    @(negedge clk);
            end
            if (n == N_RAND - 150)
                quiet = 1'b1;
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            a  = rand_operand();
            b  = ($urandom_range(0, 15) == 0) ? a
               : ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_operand();
            pending_q.push_back(alu_predict(op, a, b));
            send_beat(op, a, b);
        end
        in_valid <= 1'b0;

        wait_cnt = 0;
        while (pending_q.size() != 0 && wait_cnt < 100000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (2 * LATENCY) @(negedge clk);
        if (pending_q.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_q.size());
            n_err++;
        end

        if (n_err == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
